// File: rtl/efc_pkg.sv
// shared types, constants and crc function for the escaped frame checker
package efc_pkg;

    localparam int HeaderLenDefault = 8;
    localparam int MaxRawLenDefault = 128;

    localparam logic [7:0]  EscByte  = 8'h7d;
    localparam logic [7:0]  EscCode1 = 8'h01;
    localparam logic [7:0]  EscCode2 = 8'h02;
    localparam logic [7:0]  EscCode3 = 8'h03;
    localparam logic [7:0]  EscOut1  = 8'h7d;
    localparam logic [7:0]  EscOut2  = 8'h7f;
    localparam logic [7:0]  EscOut3  = 8'h7e;
    localparam logic [15:0] CrcInit  = 16'hffff;
    localparam logic [15:0] CrcPoly  = 16'ha001;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CRC_BAD  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_SHORT    = 3'd3,
        ST_DISABLED = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last;
        status_t    status;
    } result_t;

    // reflected crc-16 over one byte, bit by bit
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/efc_frame.sv
// frame state, unescaping, crc update and status decision for one item
module efc_frame #(
    parameter int HEADER_LEN  = efc_pkg::HeaderLenDefault,
    parameter int MAX_RAW_LEN = efc_pkg::MaxRawLenDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic             step,
    input  efc_pkg::item_t   item,
    output efc_pkg::result_t result
);

    logic        escape_pending_reg, escape_pending_next;
    logic [7:0]  raw_count_reg,      raw_count_next;
    logic [7:0]  position_reg,       position_next;
    logic [15:0] body_length_reg,    body_length_next;
    logic [15:0] running_crc_reg,    running_crc_next;
    logic [15:0] received_crc_reg,   received_crc_next;

    logic        start_esc;
    logic [7:0]  raw_total;
    logic [7:0]  unesc;
    logic [17:0] p_ext;
    logic [17:0] crc_end;
    logic [17:0] crc_end_new;
    logic [7:0]  pos_inc;
    logic [15:0] body_upd;
    logic [15:0] crc_upd;
    logic [15:0] rcv_upd;
    efc_pkg::status_t st;

    always_comb
    begin
        start_esc = !escape_pending_reg && (item.data_byte == efc_pkg::EscByte)
                    && !item.frame_end;
        raw_total = (raw_count_reg == 8'hff) ? 8'hff : raw_count_reg + 8'd1;

        if (escape_pending_reg)
        begin
            case (item.data_byte)
                efc_pkg::EscCode1: unesc = efc_pkg::EscOut1;
                efc_pkg::EscCode2: unesc = efc_pkg::EscOut2;
                efc_pkg::EscCode3: unesc = efc_pkg::EscOut3;
                default:           unesc = 8'h00;
            endcase
        end
        else if (item.data_byte == efc_pkg::EscByte)
        begin
            unesc = 8'h00;
        end
        else
        begin
            unesc = item.data_byte;
        end

        p_ext   = {10'd0, position_reg};
        crc_end = 18'(HEADER_LEN) + {2'd0, body_length_reg};

        body_upd = body_length_reg;
        if (position_reg == 8'd1)
            body_upd = {unesc, 8'h00};
        else if (position_reg == 8'd2)
            body_upd = body_length_reg | {8'h00, unesc};

        crc_upd = running_crc_reg;
        rcv_upd = received_crc_reg;
        if (p_ext >= 18'd1 && p_ext <= crc_end)
            crc_upd = efc_pkg::crc16_byte(running_crc_reg, unesc);
        else if (p_ext == crc_end + 18'd1)
            rcv_upd = {unesc, 8'h00};
        else if (p_ext == crc_end + 18'd2)
            rcv_upd = received_crc_reg | {8'h00, unesc};

        pos_inc     = (position_reg == 8'hff) ? 8'hff : position_reg + 8'd1;
        crc_end_new = 18'(HEADER_LEN) + {2'd0, body_upd};

        if (raw_total >= 8'(MAX_RAW_LEN))
            st = efc_pkg::ST_TOO_LONG;
        else if ({10'd0, pos_inc} < crc_end_new + 18'd3)
            st = efc_pkg::ST_SHORT;
        else if (rcv_upd != crc_upd)
            st = efc_pkg::ST_CRC_BAD;
        else
            st = efc_pkg::ST_OK;

        // result of this item
        result.valid     = enable ? !start_esc : item.frame_end;
        result.data_byte = enable ? unesc : 8'h00;
        result.last      = item.frame_end;
        if (!enable)
            result.status = efc_pkg::ST_DISABLED;
        else if (item.frame_end)
            result.status = st;
        else
            result.status = efc_pkg::ST_OK;

        // next frame state
        escape_pending_next = escape_pending_reg;
        raw_count_next      = raw_count_reg;
        position_next       = position_reg;
        body_length_next    = body_length_reg;
        running_crc_next    = running_crc_reg;
        received_crc_next   = received_crc_reg;
        if (!enable || (item.frame_end && !start_esc))
        begin
            escape_pending_next = 1'b0;
            raw_count_next      = 8'd0;
            position_next       = 8'd0;
            body_length_next    = 16'd0;
            running_crc_next    = efc_pkg::CrcInit;
            received_crc_next   = 16'd0;
        end
        else if (start_esc)
        begin
            escape_pending_next = 1'b1;
            raw_count_next      = raw_total;
        end
        else
        begin
            escape_pending_next = 1'b0;
            raw_count_next      = raw_total;
            position_next       = pos_inc;
            body_length_next    = body_upd;
            running_crc_next    = crc_upd;
            received_crc_next   = rcv_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            raw_count_reg      <= 8'd0;
            position_reg       <= 8'd0;
            body_length_reg    <= 16'd0;
            running_crc_reg    <= efc_pkg::CrcInit;
            received_crc_reg   <= 16'd0;
        end
        else if (step)
        begin
            escape_pending_reg <= escape_pending_next;
            raw_count_reg      <= raw_count_next;
            position_reg       <= position_next;
            body_length_reg    <= body_length_next;
            running_crc_reg    <= running_crc_next;
            received_crc_reg   <= received_crc_next;
        end
    end

endmodule

// File: rtl/escaped_frame_check_crc16.sv
// top level: escaped frame checker with input and result registers
//
// raw frame bytes enter on the s_axis channel, one byte per item, with
// s_axis_tlast on the last raw byte of a frame. unescaped bytes leave on
// m_axis; the final item of a frame has m_axis_tlast set and carries the
// frame status in m_axis_tuser (0 ok, 1 crc mismatch, 2 too long,
// 3 short frame, 4 disabled). an escape byte that waits for its code
// gives no output item.
// cfg_we/cfg_data write the enable bit; while it is clear, bytes are
// dropped and each frame end gives one item with status disabled.
// one item is taken per cycle while the receiver keeps up; the input
// register advances whenever the result register is empty or being
// read, so a stalled receiver holds one result plus one queued input
// item before s_axis_tready drops.
// reset clears the frame state, both registers and the enable bit.
module escaped_frame_check_crc16 #(
    parameter int HEADER_LEN  = efc_pkg::HeaderLenDefault,
    parameter int MAX_RAW_LEN = efc_pkg::MaxRawLenDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // byte_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // data_byte
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser    // status
);

    logic             enable_reg;
    logic             in_valid_reg;
    efc_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    efc_pkg::status_t out_status_reg;
    logic             advance;
    efc_pkg::result_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    efc_frame #(
        .HEADER_LEN  (HEADER_LEN),
        .MAX_RAW_LEN (MAX_RAW_LEN)
    ) u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (enable_reg),
        .step   (advance),
        .item   (in_item_reg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= res.valid;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.data_byte <= s_axis_tdata;
            in_item_reg.frame_end <= s_axis_tlast;
        end
        if (advance)
        begin
            out_data_reg   <= res.data_byte;
            out_last_reg   <= res.last;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == efc_pkg::ST_OK))
        else $error("non-final item carries a status");

    a_dis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == efc_pkg::ST_DISABLED)
            |-> (m_axis_tdata == 8'h00 && m_axis_tlast))
        else $error("disabled status item malformed");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_dis_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !enable_reg) |=> (!m_axis_tvalid || m_axis_tlast))
        else $error("disabled block emitted a data item");

endmodule
